FILE: sv/tiled_pixel_address_remap_assert.svh
// ----------------------------------------------------------------------------
// tiled pixel address remap: assertion macros
// shared concurrent assertion forms for the remap block and its geometry unit
// ----------------------------------------------------------------------------
`ifndef TILED_PIXEL_ADDRESS_REMAP_ASSERT_SVH
`define TILED_PIXEL_ADDRESS_REMAP_ASSERT_SVH

// same-cycle implication, off during reset
`define TPAR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpar: assertion failed");

// next-cycle implication, off during reset
`define TPAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpar: assertion failed");

`endif

FILE: sv/tpar_pkg.sv
// ----------------------------------------------------------------------------
// tpar_pkg
// payload types, register indexes and sequencer states of the tiled remap
// ----------------------------------------------------------------------------
package tpar_pkg;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned SIDE_REG_W  = 9;
    localparam int unsigned WIDTH_REG_W = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_SQUARE_SIDE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 1'b1;

    // register values after reset
    localparam logic [SIDE_REG_W-1:0]  SIDE_RESET  = 9'd8;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 13'd256;

    // one source pixel
    typedef struct packed {
        logic [31:0] pixel_color;
        logic        first_pixel;
    } t_in_item;

    // one remapped pixel
    typedef struct packed {
        logic [23:0] dest_address;
        logic [31:0] color_out;
        logic        address_overflow;
    } t_out_item;

    // geometry sequencer
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_RUN,
        DIV_MUL
    } t_div_state;

endpackage

FILE: sv/tpar_geom.sv
// ----------------------------------------------------------------------------
// tpar_geom
// holds the two geometry registers, clamps them and works out the number of
// tiles per row and the padded width with a restoring divider, one bit a cycle
// ----------------------------------------------------------------------------
module tpar_geom #(
    parameter int unsigned MAX_SIDE_BITS  = 8,
    parameter int unsigned MAX_WIDTH_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tpar_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [tpar_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [MAX_SIDE_BITS:0]               o_side,
    output logic [MAX_WIDTH_BITS:0]              o_tiles,
    output logic [((MAX_WIDTH_BITS > MAX_SIDE_BITS) ?
                   MAX_WIDTH_BITS : MAX_SIDE_BITS) + 1:0] o_padded,
    output logic                                 o_busy
);

    localparam int unsigned SW = MAX_SIDE_BITS + 1;
    localparam int unsigned QW = MAX_WIDTH_BITS + 1;
    localparam int unsigned DW = ((MAX_WIDTH_BITS > MAX_SIDE_BITS) ?
                                  MAX_WIDTH_BITS : MAX_SIDE_BITS) + 2;
    localparam int unsigned CW = $clog2(DW + 1);
    localparam int unsigned SIDE_LIM  = 1 << MAX_SIDE_BITS;
    localparam int unsigned WIDTH_LIM = 1 << MAX_WIDTH_BITS;

    logic [tpar_pkg::SIDE_REG_W-1:0]  r_square_side;
    logic [tpar_pkg::WIDTH_REG_W-1:0] r_image_width;
    tpar_pkg::t_div_state             r_state, n_state;
    logic [DW-1:0]                    r_dvd, n_dvd;
    logic [SW-1:0]                    r_dvs, n_dvs;
    logic [SW-1:0]                    r_rem, n_rem;
    logic [CW-1:0]                    r_cnt, n_cnt;
    logic [QW-1:0]                    r_tiles, n_tiles;
    logic [DW-1:0]                    r_padded, n_padded;
    logic [SW-1:0]                    eff_side;
    logic [DW-1:0]                    eff_width;
    logic [SW:0]                      trial;
    logic [DW+SW-1:0]                 pad_prod;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square_side <= tpar_pkg::SIDE_RESET;
            r_image_width <= tpar_pkg::WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpar_pkg::CFG_SQUARE_SIDE: begin
                    r_square_side <= i_cfg_data[tpar_pkg::SIDE_REG_W-1:0];
                end
                tpar_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[tpar_pkg::WIDTH_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp zero to one and large values to the limit
    always_comb begin
        if (r_square_side == '0) begin
            eff_side = SW'(1);
        end else if (32'(r_square_side) > SIDE_LIM) begin
            eff_side = SW'(SIDE_LIM);
        end else begin
            eff_side = SW'(r_square_side);
        end
        if (r_image_width == '0) begin
            eff_width = DW'(1);
        end else if (32'(r_image_width) > WIDTH_LIM) begin
            eff_width = DW'(WIDTH_LIM);
        end else begin
            eff_width = DW'(r_image_width);
        end
    end

    assign trial    = {r_rem, r_dvd[DW-1]};
    assign pad_prod = r_dvd * r_dvs;

    // divider sequencer: ceil(width / side), then padded = tiles * side
    always_comb begin
        n_state  = r_state;
        n_dvd    = r_dvd;
        n_dvs    = r_dvs;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_tiles  = r_tiles;
        n_padded = r_padded;
        unique case (r_state)
            tpar_pkg::DIV_IDLE: begin
            end
            tpar_pkg::DIV_LOAD: begin
                n_dvd   = eff_width + DW'(eff_side) - DW'(1);
                n_dvs   = eff_side;
                n_rem   = '0;
                n_cnt   = CW'(DW);
                n_state = tpar_pkg::DIV_RUN;
            end
            tpar_pkg::DIV_RUN: begin
                if (trial >= {1'b0, r_dvs}) begin
                    n_rem = SW'(trial - {1'b0, r_dvs});
                    n_dvd = {r_dvd[DW-2:0], 1'b1};
                end else begin
                    n_rem = SW'(trial);
                    n_dvd = {r_dvd[DW-2:0], 1'b0};
                end
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = tpar_pkg::DIV_MUL;
                end
            end
            tpar_pkg::DIV_MUL: begin
                n_tiles  = QW'(r_dvd);
                n_padded = DW'(pad_prod);
                n_state  = tpar_pkg::DIV_IDLE;
            end
            default: begin
                n_state = tpar_pkg::DIV_LOAD;
            end
        endcase
        // any register write starts the sums over
        if (i_cfg_we) begin
            n_state = tpar_pkg::DIV_LOAD;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpar_pkg::DIV_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        r_dvd    <= n_dvd;
        r_dvs    <= n_dvs;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_tiles  <= n_tiles;
        r_padded <= n_padded;
    end

    assign o_side   = r_dvs;
    assign o_tiles  = r_tiles;
    assign o_padded = r_padded;
    assign o_busy   = (r_state != tpar_pkg::DIV_IDLE);

    // checks
    `include "tiled_pixel_address_remap_assert.svh"

    `TPAR_ASSERT_NEXT(a_write_makes_busy, i_clk, i_rst_n, i_cfg_we, o_busy)
    `TPAR_ASSERT_NOW(a_padded_in_range, i_clk, i_rst_n, !o_busy,
        (r_padded >= DW'(r_dvs)) && (r_padded < eff_width + DW'(eff_side)))
    `TPAR_ASSERT_NOW(a_tiles_nonzero, i_clk, i_rst_n, !o_busy, r_tiles != '0)

endmodule

FILE: sv/tiled_pixel_address_remap.sv
// ----------------------------------------------------------------------------
// tiled_pixel_address_remap
// maps a linear pixel stream onto square tiles of a padded image and gives
// the destination index of each pixel with its colour
// ----------------------------------------------------------------------------
// channel  direction  handshake                      word
// input    in         i_in_valid / o_in_ready        tpar_pkg::t_in_item
// output   out        o_out_valid / i_out_ready      tpar_pkg::t_out_item
// config   in         i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// one word per cycle while o_in_ready is high; an accepted word is held in
// the first-stage register (counters and the row/column products), then in
// the output register (padded-width product) that drives o_out_valid
// after reset and after every register write the geometry divider runs
// through its load, divide and multiply states with o_in_ready low
// a stalled output holds its word; the input side keeps taking words until
// both pipeline registers are full
// ----------------------------------------------------------------------------
module tiled_pixel_address_remap #(
    parameter int unsigned ADDR_BITS      = 24,
    parameter int unsigned MAX_SIDE_BITS  = 8,
    parameter int unsigned MAX_WIDTH_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  tpar_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output tpar_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [tpar_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tpar_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned SW = MAX_SIDE_BITS + 1;
    localparam int unsigned QW = MAX_WIDTH_BITS + 1;
    localparam int unsigned PW = ((MAX_WIDTH_BITS > MAX_SIDE_BITS) ?
                                  MAX_WIDTH_BITS : MAX_SIDE_BITS) + 2;
    localparam int unsigned YW = MAX_SIDE_BITS + MAX_WIDTH_BITS;
    localparam int unsigned AW = PW + YW + 1;
    localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

    logic [SW-1:0]             geom_side;
    logic [QW-1:0]             geom_tiles;
    logic [PW-1:0]             geom_padded;
    logic                      geom_busy;

    logic [MAX_SIDE_BITS-1:0]  r_ix, r_iy, n_ix, n_iy, e_ix, e_iy;
    logic [MAX_WIDTH_BITS-1:0] r_tc, r_tr, n_tc, n_tr, e_tc, e_tr;
    logic                      r_s1_vld;
    logic [YW-1:0]             r_s1_x, r_s1_y;
    logic [31:0]               r_s1_color;
    logic                      r_out_vld;
    tpar_pkg::t_out_item       r_out;

    logic                      in_acc, s1_adv;
    logic [SW+MAX_WIDTH_BITS-1:0] col_prod, row_prod;
    logic [PW+YW-1:0]          addr_prod;
    logic [AW-1:0]             addr;

    // geometry unit
    tpar_geom #(
        .MAX_SIDE_BITS  (MAX_SIDE_BITS),
        .MAX_WIDTH_BITS (MAX_WIDTH_BITS)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_side      (geom_side),
        .o_tiles     (geom_tiles),
        .o_padded    (geom_padded),
        .o_busy      (geom_busy)
    );

    // handshake
    assign s1_adv     = !r_out_vld || i_out_ready;
    assign o_in_ready = !geom_busy && (!r_s1_vld || s1_adv);
    assign in_acc     = i_in_valid && o_in_ready;

    // counters as seen by this pixel, cleared on the first pixel
    always_comb begin
        e_ix = i_in_item.first_pixel ? '0 : r_ix;
        e_iy = i_in_item.first_pixel ? '0 : r_iy;
        e_tc = i_in_item.first_pixel ? '0 : r_tc;
        e_tr = i_in_item.first_pixel ? '0 : r_tr;
    end

    // advance inside the tile, then across, then down
    always_comb begin
        n_ix = e_ix;
        n_iy = e_iy;
        n_tc = e_tc;
        n_tr = e_tr;
        if ({1'b0, e_ix} + SW'(1) >= geom_side) begin
            n_ix = '0;
            if ({1'b0, e_iy} + SW'(1) >= geom_side) begin
                n_iy = '0;
                if ({1'b0, e_tc} + QW'(1) >= geom_tiles) begin
                    n_tc = '0;
                    n_tr = e_tr + MAX_WIDTH_BITS'(1);
                end else begin
                    n_tc = e_tc + MAX_WIDTH_BITS'(1);
                end
            end else begin
                n_iy = e_iy + MAX_SIDE_BITS'(1);
            end
        end else begin
            n_ix = e_ix + MAX_SIDE_BITS'(1);
        end
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ix <= '0;
            r_iy <= '0;
            r_tc <= '0;
            r_tr <= '0;
        end else if (in_acc) begin
            r_ix <= n_ix;
            r_iy <= n_iy;
            r_tc <= n_tc;
            r_tr <= n_tr;
        end
    end

    // first stage: pixel coordinates in the padded image
    assign col_prod = geom_side * e_tc;
    assign row_prod = geom_side * e_tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x     <= YW'(col_prod) + YW'(e_ix);
            r_s1_y     <= YW'(row_prod) + YW'(e_iy);
            r_s1_color <= i_in_item.pixel_color;
        end
    end

    // second stage: linear index and range check
    assign addr_prod = geom_padded * r_s1_y;
    assign addr      = AW'(addr_prod) + AW'(r_s1_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out.dest_address     <= 24'(64'(addr) & ADDR_MASK);
            r_out.color_out        <= r_s1_color;
            r_out.address_overflow <= (64'(addr) > ADDR_MASK);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // checks
    `include "tiled_pixel_address_remap_assert.svh"

    `TPAR_ASSERT_NEXT(a_first_at_origin, i_clk, i_rst_n,
        in_acc && i_in_item.first_pixel, (r_s1_x == '0) && (r_s1_y == '0))
    `TPAR_ASSERT_NEXT(a_stage_moves_on, i_clk, i_rst_n,
        r_s1_vld && !r_out_vld, r_out_vld)
    `TPAR_ASSERT_NEXT(a_counters_hold_when_idle, i_clk, i_rst_n,
        !in_acc, $stable(r_ix) && $stable(r_iy) && $stable(r_tc) && $stable(r_tr))

endmodule

FILE: sim/tiled_pixel_address_remap_tb.sv
// ----------------------------------------------------------------------------
// tiled_pixel_address_remap_tb
// self-checking bench for the linear-to-tiled address remap: drives pixel
// words with random gaps, stalls the result side, predicts every destination
// address from its own copy of the tile counters and compares field by field
// ----------------------------------------------------------------------------
module tiled_pixel_address_remap_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ADDR_W       = 24;
    localparam int unsigned SIDE_BITS    = 8;
    localparam int unsigned WIDTH_BITS   = 12;
    localparam int unsigned SIDE_LIMIT   = 1 << SIDE_BITS;
    localparam int unsigned WIDTH_LIMIT  = 1 << WIDTH_BITS;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned DATA_W       = tpar_pkg::CFG_DATA_W;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    tpar_pkg::t_in_item               i_in_item;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    tpar_pkg::t_out_item              o_out_item;
    logic                             i_cfg_we;
    logic [tpar_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]                i_cfg_data;

    // predictor copy of registers and position counters
    logic [tpar_pkg::SIDE_REG_W-1:0]  side_reg;
    logic [tpar_pkg::WIDTH_REG_W-1:0] width_reg;
    logic [SIDE_BITS-1:0]   pos_x;
    logic [SIDE_BITS-1:0]   pos_y;
    logic [WIDTH_BITS-1:0]  tile_col;
    logic [WIDTH_BITS-1:0]  tile_row;

    tpar_pkg::t_out_item expected_pixels[$];
    bit          no_gaps = 1'b0;
    int unsigned errors = 0;
    int unsigned pixels_sent = 0;
    int unsigned pixels_checked = 0;
    int unsigned overflows_seen = 0;
    int unsigned reg_writes = 0;

    tiled_pixel_address_remap #(
        .ADDR_BITS      (ADDR_W),
        .MAX_SIDE_BITS  (SIDE_BITS),
        .MAX_WIDTH_BITS (WIDTH_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // destination of one pixel, then step the tile counters
    function automatic tpar_pkg::t_out_item remap_pixel(input tpar_pkg::t_in_item px);
        longint unsigned side;
        longint unsigned width;
        longint unsigned tiles;
        longint unsigned padded;
        longint unsigned x;
        longint unsigned y;
        longint unsigned addr;
        tpar_pkg::t_out_item res;
        side  = 64'(side_reg);
        width = 64'(width_reg);
        if (side == 0) side = 1;
        if (side > SIDE_LIMIT) side = SIDE_LIMIT;
        if (width == 0) width = 1;
        if (width > WIDTH_LIMIT) width = WIDTH_LIMIT;
        tiles  = (width + side - 1) / side;
        padded = tiles * side;
        if (px.first_pixel) begin
            pos_x    = '0;
            pos_y    = '0;
            tile_col = '0;
            tile_row = '0;
        end
        y    = side * tile_row + pos_y;
        x    = side * tile_col + pos_x;
        addr = padded * y + x;
        res.dest_address     = addr[ADDR_W-1:0];
        res.color_out        = px.pixel_color;
        res.address_overflow = (addr >> ADDR_W) != 0;
        // counters left over from an older geometry wrap on the next step
        if (pos_x + 1 >= side) begin
            pos_x = '0;
            if (pos_y + 1 >= side) begin
                pos_y = '0;
                if (tile_col + 1 >= tiles) begin
                    tile_col = '0;
                    tile_row = tile_row + 1'b1;
                end else begin
                    tile_col = tile_col + 1'b1;
                end
            end else begin
                pos_y = pos_y + 1'b1;
            end
        end else begin
            pos_x = pos_x + 1'b1;
        end
        return res;
    endfunction

    // one pixel word onto the input channel
    task automatic send_pixel(input logic [31:0] color, input logic first);
        tpar_pkg::t_in_item px;
        px.pixel_color = color;
        px.first_pixel = first;
        if (!no_gaps && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 30);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        expected_pixels.push_back(remap_pixel(px));
        pixels_sent++;
    endtask

    // stop sending and let the pipeline empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, block idle
    task automatic write_reg(input logic [tpar_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == tpar_pkg::CFG_SQUARE_SIDE) side_reg = data[tpar_pkg::SIDE_REG_W-1:0];
        else width_reg = data[tpar_pkg::WIDTH_REG_W-1:0];
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // register value: mostly small, sometimes zero, one, the limit or beyond
    function automatic logic [DATA_W-1:0] pick_reg_value(input int unsigned limit,
                                                         input int unsigned typical);
        unique case ($urandom_range(9))
            0: return '0;
            1: return DATA_W'(1);
            2: return DATA_W'(limit);
            3: return DATA_W'($urandom_range(limit + 1, (1 << DATA_W) - 1));
            default: return DATA_W'($urandom_range(1, typical));
        endcase
    endfunction

    // result side: random stalls
    always @(posedge i_clk) begin
        i_out_ready <= no_gaps || ($urandom_range(99) >= 9);
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        tpar_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t ns: unexpected result word, got %h", $time, o_out_item);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (want.address_overflow) overflows_seen++;
                if (o_out_item.dest_address !== want.dest_address) begin
                    $display("%0t ns: dest_address expected %h, got %h",
                             $time, want.dest_address, o_out_item.dest_address);
                    errors++;
                end
                if (o_out_item.color_out !== want.color_out) begin
                    $display("%0t ns: color_out expected %h, got %h",
                             $time, want.color_out, o_out_item.color_out);
                    errors++;
                end
                if (o_out_item.address_overflow !== want.address_overflow) begin
                    $display("%0t ns: address_overflow expected %b, got %b",
                             $time, want.address_overflow, o_out_item.address_overflow);
                    errors++;
                end
            end
        end
    end

    // default geometry, extreme colours, restart in mid stream
    task automatic test_reset_defaults();
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hAAAA_AAAA, 1'b0);
        send_pixel(32'h5555_5555, 1'b1);
        send_pixel(32'h8000_0001, 1'b0);
        drain_results();
    endtask

    // zero, one, limit and beyond-limit register values, plus uneven padding
    task automatic test_register_extremes();
        logic [DATA_W-1:0] sides[5];
        logic [DATA_W-1:0] widths[5];
        sides  = '{0, 1, SIDE_LIMIT, 13'h1FFF, 3};
        widths = '{0, 1, WIDTH_LIMIT, 13'h1FFF, 10};
        for (int i = 0; i < 5; i++) begin
            write_reg(tpar_pkg::CFG_SQUARE_SIDE, sides[i]);
            write_reg(tpar_pkg::CFG_IMAGE_WIDTH, widths[i]);
            send_pixel($urandom(), 1'b1);
            send_pixel($urandom(), 1'b0);
            drain_results();
        end
    endtask

    // shrink the tile while the inner counter sits past the new side
    task automatic test_counter_beyond_limit();
        write_reg(tpar_pkg::CFG_SQUARE_SIDE, 8);
        write_reg(tpar_pkg::CFG_IMAGE_WIDTH, 16);
        send_pixel($urandom(), 1'b1);
        repeat (4) send_pixel($urandom(), 1'b0);
        drain_results();
        write_reg(tpar_pkg::CFG_SQUARE_SIDE, 2);
        write_reg(tpar_pkg::CFG_IMAGE_WIDTH, 2);
        repeat (4) send_pixel($urandom(), 1'b0);
        drain_results();
    endtask

    // climb a few tile rows with one-pixel tiles, widen to reach
    // overflowing addresses, then narrow again
    task automatic test_address_overflow();
        write_reg(tpar_pkg::CFG_SQUARE_SIDE, 1);
        write_reg(tpar_pkg::CFG_IMAGE_WIDTH, 1);
        send_pixel($urandom(), 1'b1);
        repeat (20) send_pixel($urandom(), 1'b0);
        drain_results();
        write_reg(tpar_pkg::CFG_SQUARE_SIDE, SIDE_LIMIT);
        write_reg(tpar_pkg::CFG_IMAGE_WIDTH, WIDTH_LIMIT);
        repeat (2) send_pixel($urandom(), 1'b0);
        drain_results();
        write_reg(tpar_pkg::CFG_SQUARE_SIDE, 1);
        write_reg(tpar_pkg::CFG_IMAGE_WIDTH, 1);
        repeat (3) send_pixel($urandom(), 1'b0);
        drain_results();
    endtask

    // random geometries, each phase an image run with random restarts
    task automatic test_random_stream();
        int unsigned n_items;
        int unsigned phase_len;
        bit          restart;
        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            no_gaps = (n_items >= 150 && n_items < 260);
            if ($urandom_range(3) != 0)
                write_reg(tpar_pkg::CFG_SQUARE_SIDE, pick_reg_value(SIDE_LIMIT, 16));
            if ($urandom_range(3) != 0)
                write_reg(tpar_pkg::CFG_IMAGE_WIDTH, pick_reg_value(WIDTH_LIMIT, 200));
            phase_len = $urandom_range(10, 60);
            restart   = ($urandom_range(4) != 0);
            for (int unsigned k = 0; k < phase_len; k++) begin
                send_pixel($urandom(), (k == 0 && restart) || ($urandom_range(49) == 0));
            end
            n_items += phase_len;
            drain_results();
        end
        no_gaps = 1'b0;
    endtask

    // main sequence
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        side_reg  = tpar_pkg::SIDE_RESET;
        width_reg = tpar_pkg::WIDTH_RESET;
        pos_x     = '0;
        pos_y     = '0;
        tile_col  = '0;
        tile_row  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_counter_beyond_limit();
        test_address_overflow();
        test_random_stream();

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("pixels remapped: %0d sent, %0d checked, %0d with address overflow",
                 pixels_sent, pixels_checked, overflows_seen);
        $display("register writes: %0d, mismatches: %0d", reg_writes, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d words outstanding", expected_pixels.size());
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/tpar_pkg.sv
sv/tpar_geom.sv
sv/tiled_pixel_address_remap.sv
sim/tiled_pixel_address_remap_tb.sv
